### rtl/btr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_pkg
// shared types, constants and the bounding box clamp for the triangle
// rasterizer
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int CoordW   = 13;
  localparam int PixW     = 12;
  localparam int DeltaW   = 14;
  localparam int ProdW    = 28;
  localparam int CrossW   = 29;
  localparam int SumW     = 30;
  localparam int ColorW   = 24;
  localparam int SizeW    = 13;
  localparam int CfgIdxW  = 1;
  localparam int InDataW  = 104;
  localparam int OutDataW = 56;

  localparam logic [SizeW-1:0] MaxDim       = 13'd4096;
  localparam logic [SizeW-1:0] SizeResetVal = 13'd800;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // slave tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [1:0]               pad;
    logic [ColorW-1:0]        fill_color;
    logic signed [CoordW-1:0] corner_c_y;
    logic signed [CoordW-1:0] corner_c_x;
    logic signed [CoordW-1:0] corner_b_y;
    logic signed [CoordW-1:0] corner_b_x;
    logic signed [CoordW-1:0] corner_a_y;
    logic signed [CoordW-1:0] corner_a_x;
  } in_data_t;

  // master tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic [ColorW-1:0] pixel_color;
    logic              inside_res;
    logic [PixW-1:0]   pixel_y;
    logic [PixW-1:0]   pixel_x;
  } out_data_t;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [DeltaW-1:0] ux;
    logic signed [DeltaW-1:0] uy;
    logic signed [DeltaW-1:0] vx;
    logic signed [DeltaW-1:0] vy;
    logic [ColorW-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0]          px;
    logic [PixW-1:0]          py;
    logic                     last;
    logic [ColorW-1:0]        color;
    logic signed [DeltaW-1:0] wx;
    logic signed [DeltaW-1:0] wy;
    logic signed [DeltaW-1:0] ux;
    logic signed [DeltaW-1:0] uy;
    logic signed [DeltaW-1:0] vx;
    logic signed [DeltaW-1:0] vy;
    logic signed [CrossW-1:0] z;
  } pix_item_t;

  typedef struct packed {
    logic [PixW-1:0]          px;
    logic [PixW-1:0]          py;
    logic                     last;
    logic [ColorW-1:0]        color;
    logic signed [CrossW-1:0] u;
    logic signed [CrossW-1:0] v;
    logic signed [CrossW-1:0] z;
  } uv_item_t;

  typedef struct packed {
    logic            ok;
    logic [PixW-1:0] lo;
    logic [PixW-1:0] hi;
  } axis_range_t;

  function automatic axis_range_t clamp_axis(
    logic signed [CoordW-1:0] c0,
    logic signed [CoordW-1:0] c1,
    logic signed [CoordW-1:0] c2,
    logic [SizeW-1:0]         size
  );
    logic [SizeW-1:0]         sz;
    logic signed [DeltaW-1:0] top;
    logic signed [DeltaW-1:0] cmin;
    logic signed [DeltaW-1:0] cmax;
    logic signed [DeltaW-1:0] mn;
    logic signed [DeltaW-1:0] mx;
    axis_range_t              r;
    sz   = (size > MaxDim) ? MaxDim : size;
    top  = $signed({1'b0, sz}) - 14'sd1;
    cmin = DeltaW'(c0);
    if (DeltaW'(c1) < cmin) cmin = DeltaW'(c1);
    if (DeltaW'(c2) < cmin) cmin = DeltaW'(c2);
    cmax = DeltaW'(c0);
    if (DeltaW'(c1) > cmax) cmax = DeltaW'(c1);
    if (DeltaW'(c2) > cmax) cmax = DeltaW'(c2);
    mn = (cmin < top) ? cmin : top;
    if (mn < 14'sd0) mn = 14'sd0;
    mx = (cmax > 14'sd0) ? cmax : 14'sd0;
    if (mx > top) mx = top;
    r.ok = !(mn > mx);
    r.lo = mn[PixW-1:0];
    r.hi = mx[PixW-1:0];
    return r;
  endfunction

endpackage

### rtl/barycentric_triangle_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_triangle_rasterizer
// loads a triangle, then walks its clamped bounding box one pixel per step
// (x outer, y inner) and flags the pixels inside the triangle
// ----------------------------------------------------------------------------
// A load transfer (tuser low) takes three signed corners and a fill color,
// clamps the triangle's bounding box to the image size set by the two size
// registers and produces no output. Each step transfer (tuser high) after
// that yields one pixel of the box with its inside flag, the fill color and
// tlast on the final pixel; steps while no box is pending yield nothing.
// The inside test is an exact integer sign test on the barycentric cross
// products. The block takes one transfer per clock unless m_axis_tready
// stalls it. A taken step passes the input register, scan register, cross
// product register (one 14x14 multiply per product), then the output
// register after the sign test. Size register writes apply to the next load.
module barycentric_triangle_rasterizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [btr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [btr_pkg::SizeW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
  // fill_color, zero pad
  input  logic [btr_pkg::InDataW-1:0]    s_axis_tdata,
  // operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, inside_res, pixel_color, zero pad
  output logic [btr_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  import btr_pkg::*;

  logic [SizeW-1:0] width_q, height_q;

  in_item_t  in_q, in_d;
  logic      in_vld_q, in_vld_d;
  pix_item_t pix_q, pix_d;
  logic      pix_vld_q, pix_vld_d;
  uv_item_t  uv_q, uv_d;
  logic      uv_vld_q, uv_vld_d;
  out_data_t out_q, out_d;
  logic      out_last_q, out_last_d;
  logic      out_vld_q, out_vld_d;

  logic signed [CoordW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [DeltaW-1:0] ux_q, ux_d, uy_q, uy_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [CrossW-1:0] z_q, z_d;
  logic [ColorW-1:0]        color_q, color_d;
  logic [PixW-1:0]          xlo_q, xlo_d, xhi_q, xhi_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic [PixW-1:0]          scan_x_q, scan_x_d, scan_y_q, scan_y_d;
  logic                     busy_q, busy_d;

  logic out_rdy, uv_rdy, pix_rdy, in_adv, uv_adv, pix_adv;
  logic step_last;

  in_data_t                 din;
  axis_range_t              rng_x, rng_y;
  logic signed [ProdW-1:0]  zp_a, zp_b;
  logic signed [ProdW-1:0]  up_a, up_b, vp_a, vp_b;
  logic signed [SumW-1:0]   uv_sum, z_ext;
  logic                     hit;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeResetVal;
      height_q <= SizeResetVal;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ready chain
  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign uv_rdy        = !uv_vld_q || out_rdy;
  assign pix_rdy       = !pix_vld_q || uv_rdy;
  assign in_adv        = in_vld_q && pix_rdy;
  assign s_axis_tready = !in_vld_q || pix_rdy;
  assign uv_adv        = uv_vld_q && out_rdy;
  assign pix_adv       = pix_vld_q && uv_rdy;

  // input stage
  assign din = in_data_t'(s_axis_tdata);

  always_comb begin
    in_d     = in_q;
    in_vld_d = in_vld_q && !in_adv;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d    = 1'b1;
      in_d.op     = op_e'(s_axis_tuser);
      in_d.ax     = din.corner_a_x;
      in_d.ay     = din.corner_a_y;
      in_d.bx     = din.corner_b_x;
      in_d.by     = din.corner_b_y;
      in_d.cx     = din.corner_c_x;
      in_d.cy     = din.corner_c_y;
      in_d.ux     = DeltaW'(din.corner_c_x) - DeltaW'(din.corner_a_x);
      in_d.uy     = DeltaW'(din.corner_c_y) - DeltaW'(din.corner_a_y);
      in_d.vx     = DeltaW'(din.corner_b_x) - DeltaW'(din.corner_a_x);
      in_d.vy     = DeltaW'(din.corner_b_y) - DeltaW'(din.corner_a_y);
      in_d.color  = din.fill_color;
    end
  end

  // load and scan
  assign rng_x     = clamp_axis(in_q.ax, in_q.bx, in_q.cx, width_q);
  assign rng_y     = clamp_axis(in_q.ay, in_q.by, in_q.cy, height_q);
  assign zp_a      = in_q.ux * in_q.vy;
  assign zp_b      = in_q.vx * in_q.uy;
  assign step_last = (scan_x_q == xhi_q) && (scan_y_q == yhi_q);

  always_comb begin
    ax_d      = ax_q;
    ay_d      = ay_q;
    ux_d      = ux_q;
    uy_d      = uy_q;
    vx_d      = vx_q;
    vy_d      = vy_q;
    z_d       = z_q;
    color_d   = color_q;
    xlo_d     = xlo_q;
    xhi_d     = xhi_q;
    ylo_d     = ylo_q;
    yhi_d     = yhi_q;
    scan_x_d  = scan_x_q;
    scan_y_d  = scan_y_q;
    busy_d    = busy_q;
    pix_d     = pix_q;
    pix_vld_d = pix_vld_q && !pix_adv;
    if (in_adv) begin
      if (in_q.op == OP_LOAD) begin
        ax_d     = in_q.ax;
        ay_d     = in_q.ay;
        ux_d     = in_q.ux;
        uy_d     = in_q.uy;
        vx_d     = in_q.vx;
        vy_d     = in_q.vy;
        z_d      = CrossW'(zp_a) - CrossW'(zp_b);
        color_d  = in_q.color;
        xlo_d    = rng_x.lo;
        xhi_d    = rng_x.hi;
        ylo_d    = rng_y.lo;
        yhi_d    = rng_y.hi;
        scan_x_d = rng_x.lo;
        scan_y_d = rng_y.lo;
        busy_d   = rng_x.ok && rng_y.ok;
      end else if (busy_q) begin
        pix_vld_d   = 1'b1;
        pix_d.px    = scan_x_q;
        pix_d.py    = scan_y_q;
        pix_d.last  = step_last;
        pix_d.color = color_q;
        pix_d.wx    = DeltaW'(ax_q) - $signed({2'b00, scan_x_q});
        pix_d.wy    = DeltaW'(ay_q) - $signed({2'b00, scan_y_q});
        pix_d.ux    = ux_q;
        pix_d.uy    = uy_q;
        pix_d.vx    = vx_q;
        pix_d.vy    = vy_q;
        pix_d.z     = z_q;
        if (step_last) begin
          busy_d = 1'b0;
        end else if (scan_y_q == yhi_q) begin
          scan_y_d = ylo_q;
          scan_x_d = scan_x_q + 12'd1;
        end else begin
          scan_y_d = scan_y_q + 12'd1;
        end
      end
    end
  end

  // cross products
  assign up_a = pix_q.vx * pix_q.wy;
  assign up_b = pix_q.wx * pix_q.vy;
  assign vp_a = pix_q.wx * pix_q.uy;
  assign vp_b = pix_q.ux * pix_q.wy;

  always_comb begin
    uv_d     = uv_q;
    uv_vld_d = uv_vld_q && !uv_adv;
    if (pix_adv) begin
      uv_vld_d    = 1'b1;
      uv_d.px     = pix_q.px;
      uv_d.py     = pix_q.py;
      uv_d.last   = pix_q.last;
      uv_d.color  = pix_q.color;
      uv_d.u      = CrossW'(up_a) - CrossW'(up_b);
      uv_d.v      = CrossW'(vp_a) - CrossW'(vp_b);
      uv_d.z      = pix_q.z;
    end
  end

  // sign test and output register
  assign uv_sum = SumW'(uv_q.u) + SumW'(uv_q.v);
  assign z_ext  = SumW'(uv_q.z);
  assign hit    = (uv_q.z > 29'sd0 && uv_q.u >= 29'sd0 && uv_q.v >= 29'sd0 &&
                   uv_sum <= z_ext) ||
                  (uv_q.z < 29'sd0 && uv_q.u <= 29'sd0 && uv_q.v <= 29'sd0 &&
                   uv_sum >= z_ext);

  always_comb begin
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    if (uv_adv) begin
      out_vld_d         = 1'b1;
      out_d.pad         = '0;
      out_d.pixel_x     = uv_q.px;
      out_d.pixel_y     = uv_q.py;
      out_d.inside_res  = hit;
      out_d.pixel_color = uv_q.color;
      out_last_d        = uv_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pix_vld_q <= 1'b0;
      uv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      busy_q    <= 1'b0;
      xlo_q     <= '0;
      xhi_q     <= '0;
      ylo_q     <= '0;
      yhi_q     <= '0;
      scan_x_q  <= '0;
      scan_y_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      pix_vld_q <= pix_vld_d;
      uv_vld_q  <= uv_vld_d;
      out_vld_q <= out_vld_d;
      busy_q    <= busy_d;
      xlo_q     <= xlo_d;
      xhi_q     <= xhi_d;
      ylo_q     <= ylo_d;
      yhi_q     <= yhi_d;
      scan_x_q  <= scan_x_d;
      scan_y_q  <= scan_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    pix_q      <= pix_d;
    uv_q       <= uv_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    ux_q       <= ux_d;
    uy_q       <= uy_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    z_q        <= z_d;
    color_q    <= color_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

endmodule
